// ===== hw/rtl/tpsq_pkg.sv =====
package tpsq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned HeldW       = 5;

  typedef struct packed {
    logic [7:0]  prio;
    logic        dir;
    logic [9:0]  load_time;
    logic [15:0] id;
  } entry_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_extract;
    logic empty;
    logic scan_last;
    logic shift_none;
    logic shift_last;
  } dp_status_t;

  // candidate c replaces running best b
  function automatic logic beats(entry_t c, entry_t b, logic last_dir);
    logic r;
    if (c.prio > b.prio) begin
      r = 1'b1;
    end else if (c.prio != b.prio) begin
      r = 1'b0;
    end else if (c.dir != b.dir) begin
      r = (b.dir == last_dir);
    end else if (c.load_time < b.load_time) begin
      r = 1'b1;
    end else if (c.load_time == b.load_time && c.id < b.id) begin
      r = 1'b1;
    end else begin
      r = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tpsq_ram.sv =====
module tpsq_ram #(
  parameter int unsigned Width = 35,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tpsq_ctrl.sv =====
module tpsq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  tpsq_pkg::dp_status_t  dp_status_i,
  output tpsq_pkg::dp_cmd_t     dp_cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);

  tpsq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpsq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpsq_pkg::S_IDLE: begin
        if (start_i) begin
          if (dp_status_i.is_extract && !dp_status_i.empty) begin
            state_d = tpsq_pkg::S_SCAN;
          end else begin
            state_d = tpsq_pkg::S_RESP;
          end
        end
      end
      tpsq_pkg::S_SCAN: begin
        if (dp_status_i.scan_last) begin
          state_d = dp_status_i.shift_none ? tpsq_pkg::S_FIN : tpsq_pkg::S_SHIFT;
        end
      end
      tpsq_pkg::S_SHIFT: begin
        if (dp_status_i.shift_last) begin
          state_d = tpsq_pkg::S_FIN;
        end
      end
      tpsq_pkg::S_FIN:  state_d = tpsq_pkg::S_RESP;
      tpsq_pkg::S_RESP: state_d = tpsq_pkg::S_IDLE;
      default:          state_d = tpsq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o        = '0;
    dp_cmd_o.accept = (state_q == tpsq_pkg::S_IDLE) && start_i;
    dp_cmd_o.scan   = (state_q == tpsq_pkg::S_SCAN);
    dp_cmd_o.shift  = (state_q == tpsq_pkg::S_SHIFT);
    dp_cmd_o.finish = (state_q == tpsq_pkg::S_FIN);
    busy_o          = (state_q != tpsq_pkg::S_IDLE);
    done_o          = (state_q == tpsq_pkg::S_RESP);
  end

endmodule

// ===== hw/rtl/tpsq_datapath.sv =====
module tpsq_datapath #(
  parameter int unsigned Capacity = tpsq_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpsq_pkg::dp_cmd_t           dp_cmd_i,
  output tpsq_pkg::dp_status_t        dp_status_o,
  input  logic                        func_i,
  input  logic [7:0]                  entry_priority_i,
  input  logic                        entry_direction_i,
  input  logic [9:0]                  entry_load_time_i,
  input  logic [15:0]                 entry_id_i,
  input  logic                        last_direction_i,
  output logic [1:0]                  status_o,
  output logic [7:0]                  won_priority_o,
  output logic                        won_direction_o,
  output logic [9:0]                  won_load_time_o,
  output logic [15:0]                 won_id_o,
  output logic [tpsq_pkg::HeldW-1:0]  held_count_o
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned HW = tpsq_pkg::HeldW;

  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     idx_q, widx_q, best_idx_q, best_idx_new, last_idx;
  logic              first_q, last_dir_q;
  tpsq_pkg::entry_t  best_q, best_new, cand, in_entry;
  logic              take, full, is_insert;

  tpsq_pkg::status_e status_q;
  tpsq_pkg::entry_t  won_q;
  logic [CW-1:0]     held_q;
  logic [CW+HW-1:0]  held_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  tpsq_pkg::entry_t  ram_wdata;
  logic [34:0]       ram_rdata;

  tpsq_ram #(
    .Width ($bits(tpsq_pkg::entry_t)),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_entry = '{prio: entry_priority_i, dir: entry_direction_i,
                      load_time: entry_load_time_i, id: entry_id_i};
  assign cand      = tpsq_pkg::entry_t'(ram_rdata);
  assign full      = (count_q == CW'(Capacity));
  assign last_idx  = AW'(count_q - 1'b1);
  assign is_insert = (func_i == tpsq_pkg::OP_INSERT);

  assign take         = first_q || tpsq_pkg::beats(cand, best_q, last_dir_q);
  assign best_new     = take ? cand : best_q;
  assign best_idx_new = take ? idx_q : best_idx_q;

  assign dp_status_o.is_extract = (func_i == tpsq_pkg::OP_EXTRACT);
  assign dp_status_o.empty      = (count_q == '0);
  assign dp_status_o.scan_last  = (idx_q == '0);
  assign dp_status_o.shift_none = (best_idx_new == last_idx);
  assign dp_status_o.shift_last = (AW'(widx_q + 1'b1) == last_idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx_q;
    ram_wdata = cand;
    ram_raddr = '0;
    if (dp_cmd_i.accept) begin
      ram_we    = is_insert && !full;
      ram_waddr = AW'(count_q);
      ram_wdata = in_entry;
      ram_raddr = last_idx;
    end else if (dp_cmd_i.scan) begin
      ram_raddr = (idx_q == '0) ? AW'(best_idx_new + 1'b1) : AW'(idx_q - 1'b1);
    end else if (dp_cmd_i.shift) begin
      ram_we    = 1'b1;
      ram_raddr = AW'(widx_q + 2'd2);
    end
  end

  always_comb begin
    count_d = count_q;
    if (dp_cmd_i.accept && is_insert && !full) begin
      count_d = CW'(count_q + 1'b1);
    end else if (dp_cmd_i.finish) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (dp_cmd_i.accept) begin
        first_q <= 1'b1;
      end else if (dp_cmd_i.scan) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.accept) begin
      idx_q      <= last_idx;
      last_dir_q <= last_direction_i;
      won_q      <= '0;
      held_q     <= count_d;
      if (is_insert) begin
        status_q <= full ? tpsq_pkg::ST_FULL : tpsq_pkg::ST_INSERTED;
      end else begin
        status_q <= tpsq_pkg::ST_EMPTY;
      end
    end
    if (dp_cmd_i.scan) begin
      best_q     <= best_new;
      best_idx_q <= best_idx_new;
      idx_q      <= AW'(idx_q - 1'b1);
      widx_q     <= best_idx_new;
    end
    if (dp_cmd_i.shift) begin
      widx_q <= AW'(widx_q + 1'b1);
    end
    if (dp_cmd_i.finish) begin
      status_q <= tpsq_pkg::ST_EXTRACTED;
      won_q    <= best_q;
      held_q   <= count_d;
    end
  end

  assign held_ext        = {{HW{1'b0}}, held_q};
  assign status_o        = status_q;
  assign won_priority_o  = won_q.prio;
  assign won_direction_o = won_q.dir;
  assign won_load_time_o = won_q.load_time;
  assign won_id_o        = won_q.id;
  assign held_count_o    = held_ext[HW-1:0];

endmodule

// ===== hw/rtl/train_priority_select_queue_unit.sv =====
// Priority queue of up to CAPACITY entries kept in arrival order in a
// single-port-read RAM. Pulse start_i while busy_o is low; the result
// appears for exactly one cycle with done_o high and must be captured
// then, since the block cannot be stalled. busy_o drops the cycle after
// done_o. An insert, a full insert and an empty extract go straight from
// the accept to the result. An extract over n entries scans them newest
// to oldest with one RAM read per cycle, then, unless the winner is the
// newest, closes the gap with one read/write per cycle.
module train_priority_select_queue_unit #(
  parameter int unsigned CAPACITY = tpsq_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        func_i,
  input  logic [7:0]                  entry_priority_i,
  input  logic                        entry_direction_i,
  input  logic [9:0]                  entry_load_time_i,
  input  logic [15:0]                 entry_id_i,
  input  logic                        last_direction_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  won_priority_o,
  output logic                        won_direction_o,
  output logic [9:0]                  won_load_time_o,
  output logic [15:0]                 won_id_o,
  output logic [tpsq_pkg::HeldW-1:0]  held_count_o
);

  tpsq_pkg::dp_cmd_t    dp_cmd;
  tpsq_pkg::dp_status_t dp_status;

  tpsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  tpsq_datapath #(
    .Capacity (CAPACITY)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .dp_status_o       (dp_status),
    .func_i            (func_i),
    .entry_priority_i  (entry_priority_i),
    .entry_direction_i (entry_direction_i),
    .entry_load_time_i (entry_load_time_i),
    .entry_id_i        (entry_id_i),
    .last_direction_i  (last_direction_i),
    .status_o          (status_o),
    .won_priority_o    (won_priority_o),
    .won_direction_o   (won_direction_o),
    .won_load_time_o   (won_load_time_o),
    .won_id_o          (won_id_o),
    .held_count_o      (held_count_o)
  );

endmodule

// ===== hw/rtl/tpsq_checker.sv =====
module tpsq_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_o,
  input  logic                        func_i,
  input  logic [7:0]                  entry_priority_i,
  input  logic                        entry_direction_i,
  input  logic [9:0]                  entry_load_time_i,
  input  logic [15:0]                 entry_id_i,
  input  logic                        last_direction_i,
  input  logic                        done_o,
  input  logic [1:0]                  status_o,
  input  logic [7:0]                  won_priority_o,
  input  logic                        won_direction_o,
  input  logic [9:0]                  won_load_time_o,
  input  logic [15:0]                 won_id_o,
  input  logic [tpsq_pkg::HeldW-1:0]  held_count_o
);

  logic won_zero;
  assign won_zero = (won_priority_o == '0) && !won_direction_o &&
                    (won_load_time_o == '0) && (won_id_o == '0);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but busy not raised");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o ##1 !busy_o && !done_o)
    else $error("result strobe not followed by release");

  a_won_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != tpsq_pkg::ST_EXTRACTED) |-> won_zero)
    else $error("winner fields nonzero without extract");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == tpsq_pkg::ST_EMPTY) |-> (held_count_o == '0))
    else $error("empty result with nonzero count");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a start");

endmodule

bind train_priority_select_queue_unit tpsq_checker u_tpsq_checker (.*);
